// ----- hw/rtl/battery_charge_monitor_top_assert.svh -----
// ------------------------------------------------------------------------
// battery charge monitor assertion macros
// property wrappers used by the checks at the end of the top level
// ------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_MONITOR_TOP_ASSERT_SVH
`define BATTERY_CHARGE_MONITOR_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("battery charge monitor check failed");

// next-cycle implication, off while reset is asserted
`define BCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("battery charge monitor check failed");

`endif

// ----- hw/rtl/bcm_pkg.sv -----
// ------------------------------------------------------------------------
// bcm_pkg
// types, constants and discharge curve table of the battery charge monitor
// ------------------------------------------------------------------------
package bcm_pkg;

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CHEMISTRY = 1'b0;
	localparam cfg_idx_t CFG_HYSTERESIS = 1'b1;

	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned LEVEL_W = 7;

	// chemistry codes
	localparam logic [1:0] CHEM_LEAD = 2'd0;
	localparam logic [1:0] CHEM_AGM = 2'd1;
	localparam logic [1:0] CHEM_GEL = 2'd2;
	localparam logic [1:0] CHEM_UNKNOWN = 2'd3;

	// item kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_INIT = 1'b1;

	// health codes as seen on the result
	localparam logic [2:0] HEALTH_UNKNOWN = 3'd0;
	localparam logic [2:0] HEALTH_GOOD = 3'd1;
	localparam logic [2:0] HEALTH_LOW_CHECK = 3'd2;
	localparam logic [2:0] HEALTH_LOW = 3'd3;
	localparam logic [2:0] HEALTH_OFF_CHECK = 3'd4;
	localparam logic [2:0] HEALTH_OFF = 3'd5;

	typedef enum logic [5:0] {
		ST_UNKNOWN = 6'b000001,
		ST_GOOD = 6'b000010,
		ST_LOW_CHECK = 6'b000100,
		ST_LOW = 6'b001000,
		ST_OFF_CHECK = 6'b010000,
		ST_OFF = 6'b100000
	} status_t;

	// centivolt conversion and overvoltage detection
	localparam logic signed [16:0] ADC_OFFSET = 17'sd195;
	localparam logic signed [16:0] OV_LIMIT_CV = 17'sd3000;
	localparam logic [2:0] OV_RUN_MAX = 3'd5;
	localparam logic [2:0] OV_RUN_ALARM = 3'd4;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd99;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW_LIMIT = 7'd10;

	// one linear segment per chemistry, slope and offset in Q16
	typedef struct packed {
		logic        known;
		logic [11:0] hi_cv;
		logic [11:0] lo_cv;
		logic [14:0] slope;
		logic [25:0] offset;
	} curve_t;

	function automatic curve_t curve_of(input logic [1:0] chem);
		curve_t cv;
		cv = '0;
		case (chem)
			CHEM_LEAD: begin
				cv = '{1'b1, 12'd2500, 12'd2020, 15'd13653, 26'd27579515};
			end
			CHEM_AGM: begin
				cv = '{1'b1, 12'd2520, 12'd2280, 15'd27307, 26'd62259200};
			end
			CHEM_GEL: begin
				cv = '{1'b1, 12'd2450, 12'd2180, 15'd24073, 26'd52380959};
			end
			default: begin
				cv = '0;
			end
		endcase
		return cv;
	endfunction

	function automatic logic [2:0] health_of(input status_t st);
		logic [2:0] h;
		h = HEALTH_UNKNOWN;
		case (st)
			ST_UNKNOWN: h = HEALTH_UNKNOWN;
			ST_GOOD: h = HEALTH_GOOD;
			ST_LOW_CHECK: h = HEALTH_LOW_CHECK;
			ST_LOW: h = HEALTH_LOW;
			ST_OFF_CHECK: h = HEALTH_OFF_CHECK;
			ST_OFF: h = HEALTH_OFF;
			default: h = HEALTH_UNKNOWN;
		endcase
		return h;
	endfunction

endpackage

// ----- hw/rtl/battery_charge_monitor_top.sv -----
// ------------------------------------------------------------------------
// battery_charge_monitor_top
// charge level, lowest level tracking, overvoltage and health status
// ------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   action, adc_total, saved_level, load flags
//  out      from block out_valid / out_stall charge_level .. motors_enable
//  cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one item per clock sustained while out_stall is low; a request passes through the input register
//  and then the result register, and the work sits between the two registers, one multiply
//  arst_n clears control and tracking state at once, no clearing pass follows
//  out_stall holds the result; the input register takes one more request and
//  in_stall rises only while both registers are full and the result is stalled
// ------------------------------------------------------------------------
module battery_charge_monitor_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [15:0]                       adc_total,
	input  logic [7:0]                        saved_level,
	input  logic                              motor_cutoff,
	input  logic                              brush_load,
	input  logic                              vacuum_load,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [6:0]                        charge_level,
	output logic [6:0]                        lowest_level,
	output logic                              save_lowest,
	output logic [2:0]                        health,
	output logic                              overvolt_latched,
	output logic                              overvolt_alarm,
	output logic                              backlight_on,
	output logic                              motors_enable,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  bcm_pkg::cfg_idx_t                 cfg_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bcm_pkg::*;

	// configuration
	logic [1:0]         chem_q;
	logic [LEVEL_W-1:0] hyst_q;

	// input register
	logic        valid_s1;
	logic        action_s1;
	logic [15:0] adc_s1;
	logic [7:0]  saved_s1;
	logic        cutoff_s1;
	logic        brush_s1;
	logic        vacuum_s1;

	// tracking state
	logic [2:0]         ov_run_q;
	logic               ov_flag_q;
	logic [LEVEL_W-1:0] min_q;
	status_t            st_q;

	// result register
	logic               out_valid_q;
	logic [6:0]         level_q;
	logic [6:0]         lowest_q;
	logic               save_q;
	logic [2:0]         health_q;
	logic               ov_flag_out_q;
	logic               alarm_q;
	logic               light_q;
	logic               motors_q;

	logic out_load;
	logic in_take;

	assign cfg_ready = 1'b1;
	assign out_load = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_load;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chem_q <= CHEM_UNKNOWN;
			hyst_q <= 7'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHEMISTRY: chem_q <= cfg_data[1:0];
				CFG_HYSTERESIS: hyst_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			adc_s1 <= adc_total;
			saved_s1 <= saved_level;
			cutoff_s1 <= motor_cutoff;
			brush_s1 <= brush_load;
			vacuum_s1 <= vacuum_load;
		end
	end

	// charge level from the chemistry curve
	curve_t              cv;
	logic signed [16:0]  cent;
	logic signed [16:0]  hi_s;
	logic signed [16:0]  lo_s;
	logic [26:0]         prod;
	logic signed [28:0]  diff;
	logic [10:0]         quot;
	logic [LEVEL_W-1:0]  level;
	logic                ov_hit;

	assign cv = curve_of(chem_q);
	assign cent = $signed({1'b0, adc_s1}) - ADC_OFFSET;
	assign hi_s = $signed({5'b0, cv.hi_cv});
	assign lo_s = $signed({5'b0, cv.lo_cv});
	assign prod = 27'(cv.slope * cent[11:0]);
	assign diff = $signed({2'b0, prod}) - $signed({3'b0, cv.offset});
	assign quot = diff[26:16];
	assign ov_hit = cent >= OV_LIMIT_CV;

	always_comb begin
		if (!cv.known || cent <= lo_s) begin
			level = '0;
		end else if (cent >= hi_s) begin
			level = LEVEL_FULL;
		end else if (diff[28]) begin
			level = '0;
		end else if (quot > 11'(LEVEL_FULL)) begin
			level = LEVEL_FULL;
		end else begin
			level = quot[LEVEL_W-1:0];
		end
	end

	// lowest level tracking and status machine
	logic [LEVEL_W-1:0] m1, m2, m3, m4;
	logic [7:0]         m2_plus;
	logic               save_n, motors_n, light_n, alarm_n, ov_flag_n;
	logic [2:0]         ov_run_n;
	logic [LEVEL_W-1:0] min_n;
	logic [LEVEL_W-1:0] level_n;
	status_t            st_n;
	logic               min_low, min_zero;

	always_comb begin
		m1 = min_q;
		m2 = '0;
		m3 = '0;
		m4 = '0;
		m2_plus = '0;
		save_n = 1'b0;
		motors_n = 1'b0;
		light_n = 1'b0;
		alarm_n = 1'b0;
		ov_flag_n = ov_flag_q;
		ov_run_n = ov_run_q;
		min_n = min_q;
		level_n = '0;
		st_n = st_q;
		min_low = 1'b0;
		min_zero = 1'b0;
		if (action_s1 == ACT_INIT) begin
			ov_flag_n = 1'b0;
			ov_run_n = '0;
			st_n = ST_UNKNOWN;
			if (saved_s1 > 8'(LEVEL_FULL)) begin
				min_n = LEVEL_FULL;
				save_n = 1'b1;
			end else begin
				min_n = saved_s1[LEVEL_W-1:0];
			end
		end else begin
			if (ov_hit) begin
				if (ov_run_q >= OV_RUN_ALARM) begin
					ov_flag_n = 1'b1;
					alarm_n = 1'b1;
				end
				if (ov_run_q < OV_RUN_MAX) begin
					ov_run_n = ov_run_q + 3'd1;
				end
			end else begin
				ov_run_n = '0;
			end
			level_n = level;

			// full charge with motors cut off re-enables them
			if (cutoff_s1 && level == LEVEL_FULL) begin
				m1 = LEVEL_FULL;
				save_n = 1'b1;
				motors_n = 1'b1;
			end
			m2 = m1;
			if (level < m1) begin
				m2 = level;
				save_n = 1'b1;
			end
			// under full load the minimum may rise past the margin
			m2_plus = {1'b0, m2} + {1'b0, hyst_q};
			m3 = m2;
			if (brush_s1 && vacuum_s1 && {1'b0, level} > m2_plus) begin
				m3 = level;
				save_n = 1'b1;
			end
			m4 = m3;
			if (hyst_q <= LEVEL_FULL && m3 < LEVEL_FULL - hyst_q && level == LEVEL_FULL) begin
				m4 = LEVEL_FULL;
				save_n = 1'b1;
			end
			min_n = m4;

			min_zero = m4 == '0;
			min_low = !min_zero && m4 <= LEVEL_LOW_LIMIT;
			if (m4 > LEVEL_LOW_LIMIT && st_q != ST_GOOD) begin
				light_n = st_q != ST_LOW_CHECK && st_q != ST_OFF_CHECK;
				st_n = ST_GOOD;
			end else if (min_low && st_q != ST_LOW && st_q != ST_LOW_CHECK) begin
				st_n = ST_LOW_CHECK;
			end else if (min_low && st_q == ST_LOW_CHECK) begin
				st_n = ST_LOW;
			end else if (min_zero && st_q != ST_OFF && st_q != ST_OFF_CHECK) begin
				st_n = ST_OFF_CHECK;
			end else if (min_zero && st_q == ST_OFF_CHECK) begin
				st_n = ST_OFF;
			end
		end
	end

	logic step;
	assign step = valid_s1 && out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_run_q <= '0;
			ov_flag_q <= 1'b0;
			min_q <= LEVEL_FULL;
			st_q <= ST_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				ov_run_q <= ov_run_n;
				ov_flag_q <= ov_flag_n;
				min_q <= min_n;
				st_q <= st_n;
			end
			if (out_load) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			level_q <= level_n;
			lowest_q <= min_n;
			save_q <= save_n;
			health_q <= health_of(st_n);
			ov_flag_out_q <= ov_flag_n;
			alarm_q <= alarm_n;
			light_q <= light_n;
			motors_q <= motors_n;
		end
	end

	assign out_valid = out_valid_q;
	assign charge_level = level_q;
	assign lowest_level = lowest_q;
	assign save_lowest = save_q;
	assign health = health_q;
	assign overvolt_latched = ov_flag_out_q;
	assign overvolt_alarm = alarm_q;
	assign backlight_on = light_q;
	assign motors_enable = motors_q;

`include "battery_charge_monitor_top_assert.svh"

	`BCM_ASSERT_SAME(a_stall_needs_item, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	`BCM_ASSERT_SAME(a_alarm_latched, clk, arst_n, out_valid && overvolt_alarm, overvolt_latched)
	`BCM_ASSERT_SAME(a_good_above_low, clk, arst_n, out_valid && health == HEALTH_GOOD, lowest_level > LEVEL_LOW_LIMIT)
	`BCM_ASSERT_NEXT(a_min_follows_result, clk, arst_n, step, lowest_level == min_q)

endmodule
